/* rtl/core/k_nearest_candidate_keeper_assert.svh */
// assertion macros for the k-nearest candidate keeper checker
`ifndef K_NEAREST_CANDIDATE_KEEPER_ASSERT_SVH
`define K_NEAREST_CANDIDATE_KEEPER_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define KNCK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while reset is high
`define KNCK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/knck_pkg.sv */
// shared types and constants of the k-nearest candidate keeper
`timescale 1ns / 1ps

package knck_pkg;

  // count width of fill_count, capacity and the held count
  localparam int CNT_BITS = 7;
  localparam logic [CNT_BITS-1:0] CAP_RESET = 7'd32;

  // request kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic load_query;
    logic dist_step;
    logic append;
    logic replace;
    logic scan;
    logic rd_issue;
    logic out_load;
    logic out_empty;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic dist_last;
    logic can_append;
    logic replace_ok;
    logic scan_busy;
    logic held_zero;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/k_nearest_candidate_keeper.sv */
// Keeps the k candidate points closest to a query point and reads them out.
// Input stream: s_tuser is the request kind (start, candidate, readout), s_tdata
// carries the point and its identifier. A start request loads the query and
// empties the store; a candidate request is folded into the store; a readout
// request streams the held entries in slot order on the m_ side, tlast on the
// final one, or one result with m_tuser (empty) set when nothing is held.
// One request is worked on at a time; s_tready is high only while idle.
// Start: done on acceptance. Candidate: accept, 4 multiply-accumulate steps
// over the three axes on one shared multiplier, then decide and write. A
// replacement in a full store is followed by a rescan of the store ram, one
// entry per cycle through its single read port.
// Readout: per entry a ram read, then the result register load once it is free.
// The result register decouples the sides: a stalled m_tready holds the current
// result and pauses the readout, while new requests are taken once the last
// result of a readout is in the register.
// Reset empties the store and sets capacity to 32; the store ram needs no
// clearing pass. capacity is written over the APB port at address 0.
`timescale 1ns / 1ps

module k_nearest_candidate_keeper #(
  parameter int MAX_K      = 32,
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 24,
  localparam int DIST_BITS  = 2 * COORD_BITS + 2,
  localparam int IN_DATA_W  = ((3 * COORD_BITS + INDEX_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((DIST_BITS + INDEX_BITS + knck_pkg::CNT_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // coord_x, coord_y, coord_z, point_index, zero pad
  input  logic [IN_DATA_W-1:0]                  s_tdata,
  // kind
  input  logic [knck_pkg::KIND_W-1:0]           s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // dist_sq, entry_index, fill_count, zero pad
  output logic [OUT_DATA_W-1:0]                 m_tdata,
  // is_empty
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [knck_pkg::PADDR_W-1:0]          paddr,
  input  logic [knck_pkg::PDATA_W-1:0]          pwdata,
  output logic [knck_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  localparam int CNT_BITS   = knck_pkg::CNT_BITS;

  knck_pkg::cmd_t cmd;
  knck_pkg::sts_t sts;

  logic                  cfg_we;
  logic                  cap_sel;
  logic [CNT_BITS-1:0]   capacity;
  logic [DIST_BITS-1:0]  out_dist;
  logic [INDEX_BITS-1:0] out_index;
  logic [CNT_BITS-1:0]   out_fill;

  // register 0 is capacity and is aliased at words 1 to 3, words 4 to 7 are ignored
  assign cap_sel = (paddr[knck_pkg::PADDR_W-1] == 1'b0);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && cap_sel;
  assign prdata  = cap_sel ? knck_pkg::PDATA_W'(capacity) : '0;

  knck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  knck_datapath #(
    .MAX_K      (MAX_K),
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_x      (s_tdata[COORD_BITS-1:0]),
    .in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_z      (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_index  (s_tdata[3*COORD_BITS+INDEX_BITS-1:3*COORD_BITS]),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[CNT_BITS-1:0]),
    .capacity  (capacity),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_dist  (out_dist),
    .out_index (out_index),
    .out_fill  (out_fill),
    .out_empty (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = OUT_DATA_W'({out_fill, out_index, out_dist});

endmodule

/* rtl/core/knck_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module knck_ram #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/knck_datapath.sv */
// datapath: distance unit, candidate store, largest-entry tracking, result register
`timescale 1ns / 1ps

module knck_datapath #(
  parameter int MAX_K      = 32,
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  knck_pkg::cmd_t                    cmd,
  output knck_pkg::sts_t                    sts,
  input  logic signed [COORD_BITS-1:0]      in_x,
  input  logic signed [COORD_BITS-1:0]      in_y,
  input  logic signed [COORD_BITS-1:0]      in_z,
  input  logic [INDEX_BITS-1:0]             in_index,
  input  logic                              cfg_we,
  input  logic [knck_pkg::CNT_BITS-1:0]     cfg_wdata,
  output logic [knck_pkg::CNT_BITS-1:0]     capacity,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [2*COORD_BITS+1:0]           out_dist,
  output logic [INDEX_BITS-1:0]             out_index,
  output logic [knck_pkg::CNT_BITS-1:0]     out_fill,
  output logic                              out_empty,
  output logic                              out_last
);

  localparam int CNT_BITS  = knck_pkg::CNT_BITS;
  localparam int DIST_BITS = 2 * COORD_BITS + 2;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int SLOT_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int ENTRY_W   = DIST_BITS + INDEX_BITS;
  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_K);
  localparam logic [1:0] AXIS_LAST = 2'd3;

  logic signed [COORD_BITS-1:0] cand_x, cand_y, cand_z;
  logic signed [COORD_BITS-1:0] query_x, query_y, query_z;
  logic [INDEX_BITS-1:0]        cand_index;
  logic [CNT_BITS-1:0]          held_count;
  logic [SLOT_W-1:0]            largest_slot;
  logic [DIST_BITS-1:0]         largest_dist;
  logic [1:0]                   axis;
  logic [SQ_BITS-1:0]           prod;
  logic                         prod_valid;
  logic [DIST_BITS-1:0]         acc;
  logic [CNT_BITS-1:0]          walk_cnt;
  logic                         rd_pend;
  logic [SLOT_W-1:0]            rd_slot;

  logic signed [COORD_BITS-1:0] sel_c, sel_q;
  logic [DIFF_BITS-1:0]         diff, diff_abs;
  logic [COORD_BITS-1:0]        mag;
  logic [SQ_BITS-1:0]           sq;
  logic [CNT_BITS-1:0]          k_eff;
  logic                         scan_issue;
  logic [SLOT_W-1:0]            held_slot;
  logic                         ram_we, ram_re;
  logic [SLOT_W-1:0]            ram_waddr;
  logic [ENTRY_W-1:0]           ram_rdata;
  logic [DIST_BITS-1:0]         rd_dist;
  logic [INDEX_BITS-1:0]        rd_index;

  // one squared axis difference per cycle through a shared multiplier
  always_comb begin
    case (axis)
      2'd0:    begin sel_c = cand_x; sel_q = query_x; end
      2'd1:    begin sel_c = cand_y; sel_q = query_y; end
      default: begin sel_c = cand_z; sel_q = query_z; end
    endcase
  end

  assign diff     = {sel_c[COORD_BITS-1], sel_c} - {sel_q[COORD_BITS-1], sel_q};
  assign diff_abs = diff[DIFF_BITS-1] ? (~diff + 1'b1) : diff;
  assign mag      = diff_abs[COORD_BITS-1:0];
  assign sq       = mag * mag;

  always_comb begin
    if (capacity == '0) begin
      k_eff = CNT_BITS'(1);
    end else if (capacity > MAX_CNT) begin
      k_eff = MAX_CNT;
    end else begin
      k_eff = capacity;
    end
  end

  assign held_slot  = held_count[SLOT_W-1:0];
  assign scan_issue = cmd.scan && (walk_cnt < held_count);
  assign rd_dist    = ram_rdata[DIST_BITS-1:0];
  assign rd_index   = ram_rdata[ENTRY_W-1:DIST_BITS];

  assign sts.dist_last  = (axis == AXIS_LAST);
  assign sts.can_append = (held_count < k_eff);
  assign sts.replace_ok = (held_count != '0) && (largest_dist > acc);
  assign sts.scan_busy  = (walk_cnt < held_count) || rd_pend;
  assign sts.held_zero  = (held_count == '0);
  assign sts.rd_last    = ((walk_cnt + CNT_BITS'(1)) == held_count);
  assign sts.out_free   = !out_valid || out_ready;

  assign ram_we    = cmd.append || cmd.replace;
  assign ram_waddr = cmd.append ? held_slot : largest_slot;
  assign ram_re    = scan_issue || cmd.rd_issue;

  knck_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_K)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cand_index, acc}),
    .re    (ram_re),
    .raddr (walk_cnt[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cand_x     <= in_x;
      cand_y     <= in_y;
      cand_z     <= in_z;
      cand_index <= in_index;
      acc        <= '0;
    end else if (cmd.dist_step && prod_valid) begin
      acc <= acc + DIST_BITS'(prod);
    end
    if (cmd.dist_step) begin
      prod <= sq;
    end
    rd_slot <= walk_cnt[SLOT_W-1:0];
    if (cmd.out_load) begin
      out_dist  <= rd_dist;
      out_index <= rd_index;
      out_fill  <= held_count;
      out_empty <= 1'b0;
      out_last  <= sts.rd_last;
    end else if (cmd.out_empty) begin
      out_dist  <= '0;
      out_index <= '0;
      out_fill  <= '0;
      out_empty <= 1'b1;
      out_last  <= 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= knck_pkg::CAP_RESET;
      query_x      <= '0;
      query_y      <= '0;
      query_z      <= '0;
      held_count   <= '0;
      largest_slot <= '0;
      largest_dist <= '0;
      axis         <= '0;
      prod_valid   <= 1'b0;
      walk_cnt     <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.load_query) begin
        query_x      <= in_x;
        query_y      <= in_y;
        query_z      <= in_z;
        held_count   <= '0;
        largest_slot <= '0;
      end
      if (cmd.load_item) begin
        axis       <= '0;
        prod_valid <= 1'b0;
        walk_cnt   <= '0;
      end else begin
        if (cmd.dist_step) begin
          axis       <= axis + 2'd1;
          prod_valid <= 1'b1;
        end
        if (scan_issue || cmd.out_load) begin
          walk_cnt <= walk_cnt + CNT_BITS'(1);
        end
      end
      if (cmd.append) begin
        held_count <= held_count + CNT_BITS'(1);
        // ties keep the earlier slot
        if (held_count == '0 || largest_dist < acc) begin
          largest_slot <= held_slot;
          largest_dist <= acc;
        end
      end else if (cmd.replace) begin
        largest_dist <= acc;
      end else if (rd_pend && rd_dist > largest_dist) begin
        largest_slot <= rd_slot;
        largest_dist <= rd_dist;
      end
      rd_pend <= scan_issue;
      if (cmd.out_load || cmd.out_empty) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/knck_ctrl.sv */
// controller state machine of the k-nearest candidate keeper
`timescale 1ns / 1ps

module knck_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [knck_pkg::KIND_W-1:0]   in_kind,
  input  knck_pkg::sts_t                sts,
  output knck_pkg::cmd_t                cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIST    = 3'd1;
  localparam logic [2:0] ST_DECIDE  = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_RD_REQ  = 3'd4;
  localparam logic [2:0] ST_RD_WAIT = 3'd5;
  localparam logic [2:0] ST_EMPTY   = 3'd6;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          case (in_kind)
            knck_pkg::KIND_START: cmd.load_query = 1'b1;
            knck_pkg::KIND_CAND:  state_next = ST_DIST;
            knck_pkg::KIND_READ:  state_next = sts.held_zero ? ST_EMPTY : ST_RD_REQ;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIST: begin
        cmd.dist_step = 1'b1;
        if (sts.dist_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.can_append) begin
          cmd.append = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.replace_ok) begin
          cmd.replace = 1'b1;
          state_next  = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.scan_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_REQ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = sts.rd_last ? ST_IDLE : ST_RD_REQ;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_empty = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/knck_checker.sv */
// port-level checker for the k-nearest candidate keeper, bound to the top level
`timescale 1ns / 1ps
`include "k_nearest_candidate_keeper_assert.svh"

module knck_checker #(
  parameter int MAX_K      = 32,
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 24,
  localparam int DIST_BITS  = 2 * COORD_BITS + 2,
  localparam int OUT_DATA_W = ((DIST_BITS + INDEX_BITS + knck_pkg::CNT_BITS + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [OUT_DATA_W-1:0]           m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  localparam int CNT_BITS   = knck_pkg::CNT_BITS;
  localparam int FILL_LO    = DIST_BITS + INDEX_BITS;
  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_K);

  logic [CNT_BITS-1:0] fill;

  assign fill = m_tdata[FILL_LO+CNT_BITS-1:FILL_LO];

  // an empty-store result is a readout of its own
  `KNCK_ASSERT_IMPLY(a_empty_is_last, clk, rst, m_tvalid && m_tuser, m_tlast,
    "empty result without last")

  `KNCK_ASSERT_IMPLY(a_empty_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0,
    "empty result with nonzero fields")

  `KNCK_ASSERT_IMPLY(a_fill_range, clk, rst, m_tvalid && !m_tuser,
    (fill != '0) && (fill <= MAX_CNT), "fill count out of range")

  `KNCK_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind k_nearest_candidate_keeper knck_checker #(
  .MAX_K      (MAX_K),
  .COORD_BITS (COORD_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_knck_checker (.*);

/* tb/sv/k_nearest_candidate_keeper_tb.sv */
// testbench for the k-nearest candidate keeper: directed table, random requests, self-checking
`timescale 1ns / 1ps

module k_nearest_candidate_keeper_tb;

  localparam int IN_W  = 72;
  localparam int OUT_W = 72;
  localparam int DEPTH = 32;
  localparam logic [knck_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [knck_pkg::PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [knck_pkg::PADDR_W-1:0] ADDR_UNUSED   = 3'd4;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [33:0] dist_sq;
    logic [23:0] id;
    logic [6:0]  fill;
    logic        empty;
    logic        last;
  } entry_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         rk;
    logic [knck_pkg::KIND_W-1:0] kind;
    logic [15:0]       x, y, z;
    logic [23:0]       id;
    entry_t            typed;
    logic [knck_pkg::PADDR_W-1:0] addr;
    logic [31:0]       val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // coord_x, coord_y, coord_z, point_index
  logic [IN_W-1:0] s_tdata = '0;
  // kind
  logic [knck_pkg::KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // dist_sq, entry_index, fill_count, zero pad
  logic [OUT_W-1:0] m_tdata;
  // is_empty
  logic m_tuser;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [knck_pkg::PADDR_W-1:0] paddr = '0;
  logic [knck_pkg::PDATA_W-1:0] pwdata = '0;
  logic [knck_pkg::PDATA_W-1:0] prdata;
  logic pready;

  k_nearest_candidate_keeper dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [33:0] keep_dist [DEPTH];
  logic [23:0] keep_id [DEPTH];
  int unsigned keep_count = 0;
  int unsigned worst_slot = 0;
  logic signed [15:0] query_x = '0, query_y = '0, query_z = '0;
  logic [6:0] capacity_reg = knck_pkg::CAP_RESET;

  entry_t expected_entries [$];
  entry_t typed_entry;
  bit use_typed = 1'b0;

  int error_count = 0;
  int request_count = 0;
  int ignored_count = 0;
  int checked_count = 0;
  int replace_count = 0;
  int cfg_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_off = 0;
  bit hold_pending = 1'b0;
  bit hold_pending_arm = 1'b0;

  function automatic int unsigned keep_limit();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return 32'(capacity_reg);
  endfunction

  function automatic logic [33:0] dist_to_query(logic signed [15:0] x, logic signed [15:0] y,
                                                logic signed [15:0] z);
    longint dx, dy, dz;
    dx = longint'(x) - longint'(query_x);
    dy = longint'(y) - longint'(query_y);
    dz = longint'(z) - longint'(query_z);
    return 34'(dx * dx + dy * dy + dz * dz);
  endfunction

  // folds one accepted request into the predictor and queues its readout entries
  task automatic fold_request(logic [knck_pkg::KIND_W-1:0] kind, logic [15:0] x,
                              logic [15:0] y, logic [15:0] z, logic [23:0] id);
    logic [33:0] d;
    int unsigned ls;
    entry_t e;
    case (kind)
      knck_pkg::KIND_START: begin
        query_x = x;
        query_y = y;
        query_z = z;
        keep_count = 0;
        worst_slot = 0;
      end
      knck_pkg::KIND_CAND: begin
        d = dist_to_query(x, y, z);
        if (keep_count < keep_limit()) begin
          keep_dist[keep_count] = d;
          keep_id[keep_count] = id;
          if (keep_count == 0) worst_slot = 0;
          else if (keep_dist[worst_slot] < d) worst_slot = keep_count;
          keep_count++;
        end else if (keep_count != 0 && keep_dist[worst_slot] > d) begin
          keep_dist[worst_slot] = d;
          keep_id[worst_slot] = id;
          ls = worst_slot;
          // ascending strict rescan: a tie keeps the replaced slot, else the first maximum
          for (int i = 0; i < keep_count; i++)
            if (keep_dist[i] > keep_dist[ls]) ls = i;
          worst_slot = ls;
          replace_count++;
        end
      end
      knck_pkg::KIND_READ: begin
        if (use_typed) begin
          expected_entries.push_back(typed_entry);
        end else if (keep_count == 0) begin
          e = '{dist_sq: '0, id: '0, fill: '0, empty: 1'b1, last: 1'b1};
          expected_entries.push_back(e);
        end else begin
          for (int i = 0; i < keep_count; i++) begin
            e = '{dist_sq: keep_dist[i], id: keep_id[i], fill: 7'(keep_count), empty: 1'b0,
                  last: (i + 1 == keep_count)};
            expected_entries.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s at %0t ns: got 0x%0h want 0x%0h", field, $time, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    entry_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{dist_sq: m_tdata[33:0], id: m_tdata[57:34], fill: m_tdata[64:58],
              empty: m_tuser, last: m_tlast};
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.dist_sq), 64'(0));
      end else begin
        want = expected_entries.pop_front();
        checked_count++;
        if (got.dist_sq !== want.dist_sq)
          report_mismatch("dist_sq", 64'(got.dist_sq), 64'(want.dist_sq));
        if (got.id !== want.id) report_mismatch("entry_index", 64'(got.id), 64'(want.id));
        if (got.fill !== want.fill) report_mismatch("fill_count", 64'(got.fill), 64'(want.fill));
        if (got.empty !== want.empty)
          report_mismatch("is_empty", 64'(got.empty), 64'(want.empty));
        if (got.last !== want.last) report_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  // result side ready, with a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_off = HOLD_OFF_CYCLES;
      end
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off--;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(logic [knck_pkg::KIND_W-1:0] kind, logic [15:0] x, logic [15:0] y,
                      logic [15:0] z, logic [23:0] id);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {id, z, y, x};
    do @(posedge clk); while (!s_tready);
    fold_request(kind, x, y, z, id);
    if (kind == KIND_NONE) ignored_count++;
    else request_count++;
    if (kind == knck_pkg::KIND_READ && hold_pending_arm) begin
      hold_pending_arm = 1'b0;
      hold_pending = 1'b1;
    end
    @(negedge clk);
  endtask

  // drains every expected result, then lets a replacement rescan finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [knck_pkg::PADDR_W-1:0] addr, logic [31:0] val);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_CAPACITY) capacity_reg = val[6:0];
    cfg_count++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic dir_row_t item_row(logic [knck_pkg::KIND_W-1:0] kind, logic [15:0] x,
                                        logic [15:0] y, logic [15:0] z, logic [23:0] id);
    dir_row_t r;
    r = '{rk: ROW_ITEM, kind: kind, x: x, y: y, z: z, id: id, typed: '0, addr: '0, val: '0};
    return r;
  endfunction

  function automatic dir_row_t typed_read(logic [33:0] d, logic [23:0] id, logic [6:0] fill,
                                          logic empty);
    dir_row_t r;
    r = item_row(knck_pkg::KIND_READ, '0, '0, '0, '0);
    r.rk = ROW_TYPED;
    r.typed = '{dist_sq: d, id: id, fill: fill, empty: empty, last: 1'b1};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [knck_pkg::PADDR_W-1:0] addr, logic [31:0] val);
    dir_row_t r;
    r = item_row(KIND_NONE, '0, '0, '0, '0);
    r.rk = ROW_CFG;
    r.addr = addr;
    r.val = val;
    return r;
  endfunction

  function automatic logic [15:0] near_coord(logic [15:0] c);
    int r;
    r = $urandom_range(9);
    if (r < 2) return 16'($urandom_range(16'hFFFF));
    if (r == 2) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    return c + 16'($urandom_range(6)) - 16'd3;
  endfunction

  function automatic logic [15:0] query_coord();
    if ($urandom_range(3) == 0) return 16'($urandom_range(16'hFFFF));
    return 16'($urandom_range(200)) - 16'd100;
  endfunction

  // random requests: mostly start, candidates, readout; some noise
  task automatic run_segment(int quota);
    int first, pick, n;
    logic [15:0] cx, cy, cz;
    first = request_count;
    while (request_count - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        if (pick < 70) begin
          cx = query_coord();
          cy = query_coord();
          cz = query_coord();
          send(knck_pkg::KIND_START, cx, cy, cz, 24'($urandom_range(24'hFFFFFF)));
        end else begin
          // keep filling the current store, possibly past a lowered capacity
          cx = query_x;
          cy = query_y;
          cz = query_z;
        end
        n = $urandom_range(2 * keep_limit() + 3, 1);
        if (n > 40) n = 40;
        repeat (n)
          send(knck_pkg::KIND_CAND, near_coord(cx), near_coord(cy), near_coord(cz),
               24'($urandom_range(24'hFFFFFF)));
        send(knck_pkg::KIND_READ, 16'($urandom_range(16'hFFFF)),
             16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
             24'($urandom_range(24'hFFFFFF)));
      end else begin
        case ($urandom_range(2))
          0: send(KIND_NONE, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)), 24'($urandom_range(24'hFFFFFF)));
          1: send(knck_pkg::KIND_READ, '0, '0, '0, 24'($urandom_range(24'hFFFFFF)));
          default: send(knck_pkg::KIND_CAND, 16'($urandom_range(16'hFFFF)),
                        16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                        24'($urandom_range(24'hFFFFFF)));
        endcase
      end
    end
  endtask

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [$];
    int seg_caps [9];
    seg_caps = '{3, 1, 64, 127, 6, 0, 32, 4, 12};

    dir_tab.push_back(typed_read(34'd0, 24'd0, 7'd0, 1'b1));
    dir_tab.push_back(item_row(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
    dir_tab.push_back(typed_read(34'd0, 24'd0, 7'd0, 1'b1));
    dir_tab.push_back(item_row(knck_pkg::KIND_START, 16'h8000, 16'h8000, 16'h8000, 24'd0));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'hFFFFFF));
    // farthest possible point
    dir_tab.push_back(typed_read(34'd12884508675, 24'hFFFFFF, 7'd1, 1'b0));
    dir_tab.push_back(item_row(knck_pkg::KIND_START, 16'd0, 16'd0, 16'd0, 24'hFFFFFF));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd0, 16'd0, 16'd0, 24'd0));
    dir_tab.push_back(typed_read(34'd0, 24'd0, 7'd1, 1'b0));
    dir_tab.push_back(item_row(knck_pkg::KIND_START, 16'd5, -16'sd5, 16'd100, 24'd0));
    // start empties the store
    dir_tab.push_back(typed_read(34'd0, 24'd0, 7'd0, 1'b1));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd8, -16'sd5, 16'd100, 24'd1));
    // tie on append keeps the earlier slot as largest
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd5, -16'sd2, 16'd100, 24'd2));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd5, -16'sd5, 16'd96, 24'd3));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd6, -16'sd4, 16'd101, 24'd4));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'h8000, 16'h7FFF, 16'h8000, 24'd5));
    dir_tab.push_back(item_row(KIND_NONE, 16'h1234, 16'h5678, 16'h9ABC, 24'h123456));
    dir_tab.push_back(item_row(knck_pkg::KIND_READ, '0, '0, '0, '0));
    // capacity lowered below the fill: store counts as full
    dir_tab.push_back(cfg_row(ADDR_CAPACITY, 32'd2));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd5, -16'sd5, 16'd100, 24'd6));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd9, -16'sd5, 16'd100, 24'd7));
    dir_tab.push_back(item_row(knck_pkg::KIND_READ, '0, '0, '0, '0));
    dir_tab.push_back(cfg_row(ADDR_UNUSED, 32'd9));
    // zero capacity keeps one entry
    dir_tab.push_back(cfg_row(ADDR_CAPACITY, 32'd0));
    dir_tab.push_back(item_row(knck_pkg::KIND_START, 16'd1, 16'd1, 16'd1, 24'd0));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd1, 16'd1, 16'd3, 24'd8));
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd1, 16'd1, 16'd2, 24'd9));
    // equal to the largest: dropped
    dir_tab.push_back(item_row(knck_pkg::KIND_CAND, 16'd1, 16'd1, 16'd0, 24'd10));
    dir_tab.push_back(typed_read(34'd1, 24'd9, 7'd1, 1'b0));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].rk)
        ROW_CFG: cfg_write(dir_tab[i].addr, dir_tab[i].val);
        ROW_TYPED: begin
          typed_entry = dir_tab[i].typed;
          use_typed = 1'b1;
          send(dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].id);
          use_typed = 1'b0;
        end
        default: send(dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                      dir_tab[i].id);
      endcase
    end

    for (int s = 0; s < 9; s++) begin
      cfg_write(ADDR_CAPACITY, 32'(seg_caps[s]));
      case (s / 3)
        0: begin
          snd_idle_pct = 14;
          rcv_idle_pct = 66;
        end
        1: begin
          snd_idle_pct = 66;
          rcv_idle_pct = 14;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      // result side stalls a long while so requests back up
      if (s == 6) hold_pending_arm = 1'b1;
      run_segment(38);
    end

    s_tvalid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (100) @(negedge clk);

    $display("covered %0d requests plus %0d ignored, %0d results checked",
             request_count, ignored_count, checked_count);
    $display("%0d replacements in full stores, %0d register writes", replace_count, cfg_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
